FILE: hdl/arsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package arsm_pkg;

	localparam int ADDR_W = 32;
	localparam int SIZE_W = 13;
	localparam int CODE_W = 8;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SCAN   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic latch;      // capture request word
		logic dec_ins;    // decode insert range into offsets
		logic rd_ins;     // read store at insert cursor
		logic wr_ins;     // write merged word, bump cursor
		logic clr_start;  // start clear sweep, zero scan/run state
		logic clr_step;   // zero one store entry
		logic scan_rd;    // read store at scan position
		logic scan_eval;  // evaluate scan step, may load a result
		logic scan_fin;   // load deferred closing result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            ins_more;
		logic            clr_last;
		logic            out_free;
		logic            emit1;
		logic            last_step;
	} sts_t;

endpackage
`default_nettype wire

FILE: hdl/arsm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module arsm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/arsm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module arsm_ctrl import arsm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DISP = 3'd2;
	localparam logic [2:0] S_ICHK = 3'd3;
	localparam logic [2:0] S_IWR  = 3'd4;
	localparam logic [2:0] S_SEV  = 3'd5;
	localparam logic [2:0] S_SFIN = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op)
					OP_INSERT: begin
						cmd.dec_ins = 1'b1;
						state_d     = S_ICHK;
					end
					OP_SCAN: begin
						cmd.scan_rd = 1'b1;
						state_d     = S_SEV;
					end
					OP_CLEAR: begin
						cmd.clr_start = 1'b1;
						state_d       = S_CLR;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ICHK: begin
				if (sts.ins_more) begin
					cmd.rd_ins = 1'b1;
					state_d    = S_IWR;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_IWR: begin
				cmd.wr_ins = 1'b1;
				state_d    = S_ICHK;
			end
			S_SEV: begin
				if (sts.out_free) begin
					cmd.scan_eval = 1'b1;
					state_d = (sts.emit1 && sts.last_step) ? S_SFIN : S_IDLE;
				end
			end
			S_SFIN: begin
				if (sts.out_free) begin
					cmd.scan_fin = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/arsm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module arsm_dp import arsm_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int SLOTS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_index,
	input  wire logic [ADDR_W-1:0]    cfg_data,
	input  wire logic [OP_W-1:0]      opcode,
	input  wire logic [ADDR_W-1:0]    range_first,
	input  wire logic [ADDR_W-1:0]    range_last,
	input  wire logic [CODE_W-1:0]    region_code,
	input  wire logic                 rsp_ready,
	output logic                      rsp_valid,
	output logic                      run_valid,
	output logic      [ADDR_W-1:0]    run_first,
	output logic      [ADDR_W-1:0]    run_last,
	output logic      [8*SLOTS-1:0]   slot_word,
	output logic                      scan_done,
	output logic                      last_of_item
);

	localparam int WORD_W = 8 * SLOTS;
	localparam int AW     = $clog2(DEPTH);
	localparam int OFW    = (AW > SIZE_W) ? AW : SIZE_W;
	localparam logic [ADDR_W-1:0] DEPTH_W = ADDR_W'(DEPTH);

	// config and derived window
	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] wsize_q;
	logic [SIZE_W-1:0] size_eff;

	// captured request
	logic [OP_W-1:0]   op_q;
	logic [ADDR_W-1:0] first_q;
	logic [ADDR_W-1:0] last_q;
	logic [CODE_W-1:0] code_q;

	// insert walk
	logic              past_q;
	logic              go_q;
	logic [OFW-1:0]    cur_q;
	logic [OFW-1:0]    hi_q;

	// scan state
	logic [OFW-1:0]    pos_q;
	logic [OFW-1:0]    ro_q;
	logic [WORD_W-1:0] rv_q;

	logic [AW-1:0]     clr_cnt_q;

	// result register
	logic              rsp_valid_q;
	logic              run_valid_q;
	logic [ADDR_W-1:0] run_first_q;
	logic [ADDR_W-1:0] run_last_q;
	logic [WORD_W-1:0] slot_word_q;
	logic              scan_done_q;
	logic              last_of_item_q;

	// store port signals
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] rdata;

	// window size clamp: 0 acts as 1, above DEPTH acts as DEPTH
	always_comb begin
		if (wsize_q == '0) begin
			size_eff = SIZE_W'(1);
		end else if ({{(ADDR_W-SIZE_W){1'b0}}, wsize_q} > DEPTH_W) begin
			size_eff = SIZE_W'(DEPTH);
		end else begin
			size_eff = wsize_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			wsize_q <= SIZE_W'(4096);
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_BASE: base_q  <= cfg_data;
					REG_SIZE: wsize_q <= cfg_data[SIZE_W-1:0];
					default:  base_q  <= base_q;
				endcase
			end
		end
	end

	// insert range decode, all in window offsets
	logic              past_hit;
	logic              below;
	logic              skip;
	logic [ADDR_W-1:0] lo_full;
	logic [ADDR_W-1:0] hi_full;
	logic [ADDR_W-1:0] size_m1;
	logic [OFW-1:0]    lo_off;
	logic [OFW-1:0]    hi_off;

	always_comb begin
		lo_full  = first_q - base_q;
		hi_full  = last_q - base_q;
		size_m1  = {{(ADDR_W-SIZE_W){1'b0}}, size_eff - SIZE_W'(1)};
		// start beyond base + size; offsets are exact when first >= base
		past_hit = (first_q >= base_q) &&
		           ({{(ADDR_W-SIZE_W){1'b0}}, size_eff} < lo_full);
		below    = last_q < base_q;
		skip     = (code_q == '0) || past_q;
		lo_off   = (first_q > base_q) ? OFW'(lo_full) : '0;
		hi_off   = (hi_full < size_m1) ? OFW'(hi_full) : OFW'(size_m1);
	end

	// first empty slot takes the code
	logic [WORD_W-1:0] merged;
	logic              found;

	always_comb begin
		merged = rdata;
		found  = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			if (!found && rdata[8*j +: 8] == '0) begin
				merged[8*j +: 8] = code_q;
				found            = 1'b1;
			end
		end
	end

	// scan step evaluation
	logic              pos_zero;
	logic              differ;
	logic              emit1;
	logic              last_step;
	logic [OFW:0]      pos_inc;
	logic [OFW-1:0]    ro_new;
	logic [ADDR_W-1:0] a_ro;
	logic [ADDR_W-1:0] a_pm1;
	logic [ADDR_W-1:0] a_new;
	logic [ADDR_W-1:0] a_pos;

	always_comb begin
		pos_zero  = (pos_q == '0);
		differ    = (rv_q != rdata);
		emit1     = !pos_zero && differ && (rv_q != '0);
		pos_inc   = {1'b0, pos_q} + (OFW+1)'(1);
		last_step = pos_inc >= (OFW+1)'(size_eff);
		ro_new    = (pos_zero || differ) ? pos_q : ro_q;
		a_ro      = base_q + ADDR_W'(ro_q);
		a_pm1     = base_q + ADDR_W'(pos_q) - ADDR_W'(1);
		a_new     = base_q + ADDR_W'(ro_new);
		a_pos     = base_q + ADDR_W'(pos_q);
	end

	// next result word
	logic              load;
	logic              nv;
	logic [ADDR_W-1:0] nf;
	logic [ADDR_W-1:0] nl;
	logic [WORD_W-1:0] nw;
	logic              nd;
	logic              nlast;

	always_comb begin
		load = (cmd.scan_eval && (emit1 || last_step)) || cmd.scan_fin;
		if (cmd.scan_fin) begin
			nv    = (rv_q != '0);
			nf    = a_ro;
			nl    = a_pos;
			nw    = rv_q;
			nd    = 1'b1;
			nlast = 1'b1;
		end else if (emit1) begin
			nv    = 1'b1;
			nf    = a_ro;
			nl    = a_pm1;
			nw    = rv_q;
			nd    = 1'b0;
			nlast = !last_step;
		end else begin
			nv    = (rdata != '0);
			nf    = a_new;
			nl    = a_pos;
			nw    = rdata;
			nd    = 1'b1;
			nlast = 1'b1;
		end
		if (!nv) begin
			nf = '0;
			nl = '0;
			nw = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= opcode;
			first_q <= range_first;
			last_q  <= range_last;
			code_q  <= region_code;
		end
		if (load) begin
			run_valid_q    <= nv;
			run_first_q    <= nf;
			run_last_q     <= nl;
			slot_word_q    <= nw;
			scan_done_q    <= nd;
			last_of_item_q <= nlast;
		end
		if (cmd.dec_ins) begin
			cur_q <= lo_off;
			hi_q  <= hi_off;
		end else if (cmd.wr_ins) begin
			cur_q <= cur_q + OFW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			past_q      <= 1'b0;
			go_q        <= 1'b0;
			pos_q       <= '0;
			ro_q        <= '0;
			rv_q        <= '0;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd.dec_ins) begin
				go_q <= !skip && !past_hit && !below;
				if (!skip && past_hit) past_q <= 1'b1;
			end
			if (cmd.clr_start) begin
				past_q    <= 1'b0;
				pos_q     <= '0;
				ro_q      <= '0;
				rv_q      <= '0;
				clr_cnt_q <= '0;
			end
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.scan_eval) begin
				rv_q <= rdata;
				ro_q <= ro_new;
				if (last_step && !emit1) begin
					pos_q  <= '0;
					past_q <= 1'b0;
				end else if (!last_step) begin
					pos_q <= pos_inc[OFW-1:0];
				end
			end
			if (cmd.scan_fin) begin
				pos_q  <= '0;
				past_q <= 1'b0;
			end
		end
	end

	// store access
	always_comb begin
		ram_we    = cmd.clr_step || cmd.wr_ins;
		ram_waddr = cmd.clr_step ? clr_cnt_q : cur_q[AW-1:0];
		ram_wdata = cmd.clr_step ? '0 : merged;
		ram_re    = cmd.rd_ins || cmd.scan_rd;
		ram_raddr = cmd.scan_rd ? pos_q[AW-1:0] : cur_q[AW-1:0];
	end

	arsm_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_comb begin
		sts.op        = op_q;
		sts.ins_more  = go_q && (cur_q <= hi_q);
		sts.clr_last  = (clr_cnt_q == AW'(DEPTH - 1));
		sts.out_free  = !rsp_valid_q || rsp_ready;
		sts.emit1     = emit1;
		sts.last_step = last_step;
	end

	assign rsp_valid    = rsp_valid_q;
	assign run_valid    = run_valid_q;
	assign run_first    = run_first_q;
	assign run_last     = run_last_q;
	assign slot_word    = slot_word_q;
	assign scan_done    = scan_done_q;
	assign last_of_item = last_of_item_q;

endmodule
`default_nettype wire

FILE: hdl/address_range_slot_merger_top.sv
`timescale 1ns / 1ps
// Region slot store over an address window, SLOTS byte slots per address.
// Channels: req (valid/ready) takes one word per op: insert range, scan one
// address, or clear. rsp (valid/ready) returns run words; last_of_item marks
// the final word of a request. cfg (valid/ready, always ready) writes
// window_base (index 0) and window_size (index 1); the user must write only
// while idle, which the block does not enforce; a write applies to the next request.
// Timing: a request is taken when req_ready is high; the next one can follow
// once the sequencer is back in idle.
//   scan:   accept, store read, evaluate; a closing step follows when a run
//           closes on the final address and two words go out.
//   insert: accept, decode, then a store read and a write per windowed
//           address in the range, one read-modify-write at a time.
//   clear:  accept, then a sweep that zeroes one store entry per cycle.
// Reset: asynchronous, active low. The store is swept to zero afterwards
// with req_ready low; cfg writes are still taken.
// Stall: one output register holds a waiting word; new requests are taken
// meanwhile, but a scan step waits in evaluate until the register can take
// a word, holding req_ready low.
`default_nettype none
module address_range_slot_merger_top import arsm_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int SLOTS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// config
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_index,
	input  wire logic [ADDR_W-1:0]    cfg_data,
	// request
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire logic [OP_W-1:0]      opcode,
	input  wire logic [ADDR_W-1:0]    range_first,
	input  wire logic [ADDR_W-1:0]    range_last,
	input  wire logic [CODE_W-1:0]    region_code,
	// response
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output logic                      run_valid,
	output logic      [ADDR_W-1:0]    run_first,
	output logic      [ADDR_W-1:0]    run_last,
	output logic      [8*SLOTS-1:0]   slot_word,
	output logic                      scan_done,
	output logic                      last_of_item
);

	cmd_t cmd;
	sts_t sts;

	// register writes never stall
	assign cfg_ready = 1'b1;

	arsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	arsm_dp #(
		.DEPTH(DEPTH),
		.SLOTS(SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.range_first (range_first),
		.range_last  (range_last),
		.region_code (region_code),
		.rsp_ready   (rsp_ready),
		.rsp_valid   (rsp_valid),
		.run_valid   (run_valid),
		.run_first   (run_first),
		.run_last    (run_last),
		.slot_word   (slot_word),
		.scan_done   (scan_done),
		.last_of_item(last_of_item)
	);

endmodule
`default_nettype wire
